// ===== hdl/chrt_pkg.sv =====
`timescale 1ns / 1ps

package chrt_pkg;

    localparam int REPLICA_SLOTS = 256;
    localparam int NODE_SLOTS    = 16;
    localparam int IDX_W         = $clog2(REPLICA_SLOTS);
    localparam int CNT_W         = $clog2(REPLICA_SLOTS) + 1;
    localparam int NODE_W        = 4;
    localparam int HASH_W        = 64;
    localparam int AVAIL_W       = 16;

    typedef enum logic [2:0] {
        ACT_ADD_NODE = 3'd0,
        ACT_ADD_REP  = 3'd1,
        ACT_DELETE   = 3'd2,
        ACT_FIND     = 3'd3,
        ACT_NEXT     = 3'd4,
        ACT_RESERVE  = 3'd5,
        ACT_RESTORE  = 3'd6,
        ACT_QUERY    = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_EXISTS  = 3'd1,
        STS_UNKNOWN = 3'd2,
        STS_EMPTY   = 3'd3,
        STS_NONE    = 3'd4,
        STS_FULL    = 3'd5,
        STS_BADPOS  = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL
    } cell_op_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_READ,
        FSM_DEL,
        FSM_RSV
    } fsm_t;

    typedef struct packed {
        cell_op_t            op;
        logic [HASH_W-1:0]   key;
        logic [NODE_W-1:0]   node;
    } cell_ctl_t;

    function automatic logic [IDX_W-1:0] onehot_enc(input logic [REPLICA_SLOTS-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < REPLICA_SLOTS; i++)
        begin
            if (v[i])
            begin
                r = r | IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/consistent_hash_ring_table.sv =====
`timescale 1ns / 1ps

// Consistent-hashing ring table. Replica entries (64-bit hash, 4-bit node) sit
// in a chain of 256 cells kept sorted by hash; each cell compares its hash with
// the key and shifts to a neighbor, so the cells register an insert in the cycle
// the beat is taken. Node add, replica add, restore, query and every error but
// reserve's none-left return a result in the cycle after the beat is taken. Find
// and next locate the cell, then read it and register the result. Delete removes
// one replica of the node per cycle and then posts the result. Reserve checks one
// ring position per cycle while the result slot is free. One action is in flight
// at a time; a new beat is taken while the previous result still waits on the
// output register only if that result is taken in the same cycle.
// A stalled output register holds delete, find, next and reserve in their
// last step until the result slot frees.
// Errors return all fields zero except status, besides the duplicate-add case.
module consistent_hash_ring_table (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [2:0]                        action,
    input  logic [chrt_pkg::NODE_W-1:0]       node_id,
    input  logic [chrt_pkg::HASH_W-1:0]       key_hash,
    input  logic [chrt_pkg::AVAIL_W-1:0]      avail,
    input  logic [chrt_pkg::IDX_W-1:0]        position,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        status,
    output logic [chrt_pkg::IDX_W-1:0]        position_out,
    output logic [chrt_pkg::NODE_W-1:0]       node_out,
    output logic [chrt_pkg::HASH_W-1:0]       hash_out,
    output logic [chrt_pkg::AVAIL_W-1:0]      avail_out
);
    import chrt_pkg::*;

    fsm_t                   state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [NODE_SLOTS-1:0]  present_reg, present_next;
    logic [AVAIL_W-1:0]     avail_reg [NODE_SLOTS];
    logic [IDX_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]       steps_reg, steps_next;
    logic [NODE_W-1:0]      node_reg, node_next;

    logic                   out_valid_reg, out_valid_next;
    status_t                sts_reg, sts_next;
    logic [IDX_W-1:0]       opos_reg, opos_next;
    logic [NODE_W-1:0]      onode_reg, onode_next;
    logic [HASH_W-1:0]      ohash_reg, ohash_next;
    logic [AVAIL_W-1:0]     oav_reg, oav_next;

    logic                   av_we;
    logic [NODE_W-1:0]      av_wa;
    logic [AVAIL_W-1:0]     av_wd;

    cell_ctl_t              ctl;
    logic [HASH_W-1:0]      rd_hash;
    logic [NODE_W-1:0]      rd_node;
    logic [IDX_W-1:0]       ins_pos, find_pos;
    logic                   any_match;

    logic                   in_acc, out_free, load;
    logic [CNT_W-1:0]       pos_ext, pos_inc, step_inc, rpos_inc;
    logic [AVAIL_W-1:0]     id_av, rd_av;

    chrt_ring u_ring (
        .clk       (clk),
        .ctl       (ctl),
        .cnt       (cnt_reg),
        .rd_addr   (pos_reg),
        .rd_hash   (rd_hash),
        .rd_node   (rd_node),
        .ins_pos   (ins_pos),
        .find_pos  (find_pos),
        .any_match (any_match)
    );

    // hold new beats while an action is in flight or the result slot is blocked
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != FSM_IDLE) || !out_free;
    assign in_acc   = in_valid && !in_stall;

    assign pos_ext  = {1'b0, position};
    assign pos_inc  = pos_ext + 1'b1;
    assign rpos_inc = {1'b0, pos_reg} + 1'b1;
    assign step_inc = steps_reg + 1'b1;
    assign id_av    = avail_reg[node_id];
    assign rd_av    = avail_reg[rd_node];

    assign out_valid    = out_valid_reg;
    assign status       = sts_reg;
    assign position_out = opos_reg;
    assign node_out     = onode_reg;
    assign hash_out     = ohash_reg;
    assign avail_out    = oav_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        present_next = present_reg;
        pos_next     = pos_reg;
        steps_next   = steps_reg;
        node_next    = node_reg;
        av_we        = 1'b0;
        av_wa        = node_id;
        av_wd        = avail;
        ctl.op       = CELL_HOLD;
        ctl.key      = key_hash;
        ctl.node     = node_id;
        load         = 1'b0;
        sts_next     = STS_OK;
        opos_next    = '0;
        onode_next   = '0;
        ohash_next   = '0;
        oav_next     = '0;

        case (state_reg)
            FSM_IDLE:
            begin
                if (in_acc)
                begin
                    case (action_t'(action))
                        ACT_ADD_NODE:
                        begin
                            load       = 1'b1;
                            onode_next = node_id;
                            if (present_reg[node_id])
                            begin
                                sts_next = STS_EXISTS;
                                oav_next = id_av;
                            end
                            else
                            begin
                                present_next[node_id] = 1'b1;
                                av_we    = 1'b1;
                                oav_next = avail;
                            end
                        end
                        ACT_ADD_REP:
                        begin
                            load = 1'b1;
                            if (!present_reg[node_id])
                            begin
                                sts_next = STS_UNKNOWN;
                            end
                            else if (cnt_reg == CNT_W'(REPLICA_SLOTS))
                            begin
                                sts_next = STS_FULL;
                            end
                            else
                            begin
                                ctl.op     = CELL_INS;
                                cnt_next   = cnt_reg + 1'b1;
                                opos_next  = ins_pos;
                                onode_next = node_id;
                                ohash_next = key_hash;
                                oav_next   = id_av;
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (!present_reg[node_id])
                            begin
                                load     = 1'b1;
                                sts_next = STS_UNKNOWN;
                            end
                            else
                            begin
                                present_next[node_id] = 1'b0;
                                node_next  = node_id;
                                state_next = FSM_DEL;
                            end
                        end
                        ACT_FIND:
                        begin
                            if (cnt_reg == '0)
                            begin
                                load     = 1'b1;
                                sts_next = STS_EMPTY;
                            end
                            else
                            begin
                                pos_next   = find_pos;
                                state_next = FSM_READ;
                            end
                        end
                        ACT_NEXT, ACT_RESERVE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                load     = 1'b1;
                                sts_next = STS_EMPTY;
                            end
                            else if (pos_ext >= cnt_reg)
                            begin
                                load     = 1'b1;
                                sts_next = STS_BADPOS;
                            end
                            else if (action_t'(action) == ACT_NEXT)
                            begin
                                pos_next   = (pos_inc == cnt_reg) ? '0 : pos_inc[IDX_W-1:0];
                                state_next = FSM_READ;
                            end
                            else
                            begin
                                pos_next   = position;
                                steps_next = '0;
                                state_next = FSM_RSV;
                            end
                        end
                        ACT_RESTORE, ACT_QUERY:
                        begin
                            load = 1'b1;
                            if (!present_reg[node_id])
                            begin
                                sts_next = STS_UNKNOWN;
                            end
                            else
                            begin
                                onode_next = node_id;
                                oav_next   = id_av;
                                if (action_t'(action) == ACT_RESTORE && id_av != '1)
                                begin
                                    av_we    = 1'b1;
                                    av_wd    = id_av + 1'b1;
                                    oav_next = id_av + 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            load = 1'b0;
                        end
                    endcase
                end
            end
            FSM_READ:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    opos_next  = pos_reg;
                    onode_next = rd_node;
                    ohash_next = rd_hash;
                    oav_next   = rd_av;
                    state_next = FSM_IDLE;
                end
            end
            FSM_DEL:
            begin
                // drop one replica of the node per cycle until none is left
                ctl.op   = CELL_DEL;
                ctl.node = node_reg;
                if (any_match)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
                else if (out_free)
                begin
                    load       = 1'b1;
                    onode_next = node_reg;
                    state_next = FSM_IDLE;
                end
            end
            FSM_RSV:
            begin
                if (out_free)
                begin
                    if (rd_av != '0)
                    begin
                        av_we      = 1'b1;
                        av_wa      = rd_node;
                        av_wd      = rd_av - 1'b1;
                        load       = 1'b1;
                        opos_next  = pos_reg;
                        onode_next = rd_node;
                        ohash_next = rd_hash;
                        oav_next   = rd_av - 1'b1;
                        state_next = FSM_IDLE;
                    end
                    else if (step_inc == cnt_reg)
                    begin
                        load       = 1'b1;
                        sts_next   = STS_NONE;
                        state_next = FSM_IDLE;
                    end
                    else
                    begin
                        steps_next = step_inc;
                        pos_next   = (rpos_inc == cnt_reg) ? '0 : rpos_inc[IDX_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            cnt_reg       <= '0;
            present_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            present_reg   <= present_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        steps_reg <= steps_next;
        node_reg  <= node_next;
        if (av_we)
        begin
            avail_reg[av_wa] <= av_wd;
        end
        if (load)
        begin
            sts_reg   <= sts_next;
            opos_reg  <= opos_next;
            onode_reg <= onode_next;
            ohash_reg <= ohash_next;
            oav_reg   <= oav_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(REPLICA_SLOTS))
        else $error("replica count above capacity");

    a_del_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == FSM_DEL && !any_match && out_free |=> state_reg == FSM_IDLE)
        else $error("delete did not finish once no replica was left");

    a_del_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == FSM_DEL |-> !present_reg[node_reg])
        else $error("deleted node still present");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && sts_reg != STS_OK |-> ohash_reg == '0 && opos_reg == '0)
        else $error("error result carries entry data");

endmodule

// ===== hdl/chrt_cell.sv =====
`timescale 1ns / 1ps

module chrt_cell (
    input  logic                            clk,
    input  chrt_pkg::cell_ctl_t             ctl,
    input  logic                            valid,
    input  logic                            at_end,
    input  logic                            prev_gt,
    input  logic                            shift_r,
    input  logic [chrt_pkg::HASH_W-1:0]     left_hash,
    input  logic [chrt_pkg::NODE_W-1:0]     left_node,
    input  logic [chrt_pkg::HASH_W-1:0]     right_hash,
    input  logic [chrt_pkg::NODE_W-1:0]     right_node,
    output logic [chrt_pkg::HASH_W-1:0]     hash,
    output logic [chrt_pkg::NODE_W-1:0]     node,
    output logic                            gt,
    output logic                            match
);
    import chrt_pkg::*;

    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [NODE_W-1:0] node_reg, node_next;

    assign gt    = valid && (hash_reg > ctl.key);
    assign match = valid && (node_reg == ctl.node);
    assign hash  = hash_reg;
    assign node  = node_reg;

    always_comb
    begin
        hash_next = hash_reg;
        node_next = node_reg;
        case (ctl.op)
            CELL_INS:
            begin
                // shift up behind the insertion point, load the new entry at it
                if (prev_gt)
                begin
                    hash_next = left_hash;
                    node_next = left_node;
                end
                else if (gt || at_end)
                begin
                    hash_next = ctl.key;
                    node_next = ctl.node;
                end
            end
            CELL_DEL:
            begin
                if (shift_r)
                begin
                    hash_next = right_hash;
                    node_next = right_node;
                end
            end
            default:
            begin
                hash_next = hash_reg;
                node_next = node_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
        node_reg <= node_next;
    end

endmodule

// ===== hdl/chrt_ring.sv =====
`timescale 1ns / 1ps

module chrt_ring (
    input  logic                            clk,
    input  chrt_pkg::cell_ctl_t             ctl,
    input  logic [chrt_pkg::CNT_W-1:0]      cnt,
    input  logic [chrt_pkg::IDX_W-1:0]      rd_addr,
    output logic [chrt_pkg::HASH_W-1:0]     rd_hash,
    output logic [chrt_pkg::NODE_W-1:0]     rd_node,
    output logic [chrt_pkg::IDX_W-1:0]      ins_pos,
    output logic [chrt_pkg::IDX_W-1:0]      find_pos,
    output logic                            any_match
);
    import chrt_pkg::*;

    logic [HASH_W-1:0]        hash_w [REPLICA_SLOTS];
    logic [NODE_W-1:0]        node_w [REPLICA_SLOTS];
    logic [REPLICA_SLOTS-1:0] valid_v, end_v, gt_v, match_v, shr_v, low_v;
    logic [REPLICA_SLOTS-1:0] first_gt, le_v, last_le;
    logic [CNT_W-1:0]         cnt_m1;

    // drop the lowest matching entry: every cell at or above it pulls from the right
    assign low_v = match_v & (~match_v + 1'b1);
    assign shr_v = ~(match_v ^ (match_v - 1'b1)) | low_v;
    assign any_match = |match_v;

    assign first_gt = gt_v & ~(gt_v << 1);
    assign le_v     = valid_v & ~gt_v;
    assign last_le  = le_v & ~(le_v >> 1);
    assign cnt_m1   = cnt - 1'b1;

    assign ins_pos  = (|gt_v) ? onehot_enc(first_gt) : cnt[IDX_W-1:0];
    assign find_pos = (|le_v) ? onehot_enc(last_le) : cnt_m1[IDX_W-1:0];

    assign rd_hash = hash_w[rd_addr];
    assign rd_node = node_w[rd_addr];

    for (genvar i = 0; i < REPLICA_SLOTS; i++)
    begin : g_cell
        logic                prev_gt;
        logic [HASH_W-1:0]   lh, rh;
        logic [NODE_W-1:0]   ln, rn;

        assign valid_v[i] = CNT_W'(i) < cnt;
        assign end_v[i]   = CNT_W'(i) == cnt;

        if (i == 0)
        begin : g_first
            assign prev_gt = 1'b0;
            assign lh      = ctl.key;
            assign ln      = ctl.node;
        end
        else
        begin : g_mid
            assign prev_gt = gt_v[i-1];
            assign lh      = hash_w[i-1];
            assign ln      = node_w[i-1];
        end

        if (i == REPLICA_SLOTS - 1)
        begin : g_last
            assign rh = hash_w[i];
            assign rn = node_w[i];
        end
        else
        begin : g_inner
            assign rh = hash_w[i+1];
            assign rn = node_w[i+1];
        end

        chrt_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .valid      (valid_v[i]),
            .at_end     (end_v[i]),
            .prev_gt    (prev_gt),
            .shift_r    (shr_v[i]),
            .left_hash  (lh),
            .left_node  (ln),
            .right_hash (rh),
            .right_node (rn),
            .hash       (hash_w[i]),
            .node       (node_w[i]),
            .gt         (gt_v[i]),
            .match      (match_v[i])
        );
    end

endmodule

// ===== dv/chrt_checker.sv =====
`timescale 1ns / 1ps

module chrt_checker
    import chrt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [2:0]           action,
    input  logic [NODE_W-1:0]    node_id,
    input  logic [HASH_W-1:0]    key_hash,
    input  logic [AVAIL_W-1:0]   avail,
    input  logic [IDX_W-1:0]     position,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [2:0]           status,
    input  logic [IDX_W-1:0]     position_out,
    input  logic [NODE_W-1:0]    node_out,
    input  logic [HASH_W-1:0]    hash_out,
    input  logic [AVAIL_W-1:0]   avail_out,
    output int                   fail_count,
    output int                   pending,
    output int                   beats_in,
    output int                   beats_out
);

    typedef struct packed {
        status_t             sts;
        logic [IDX_W-1:0]    pos;
        logic [NODE_W-1:0]   node;
        logic [HASH_W-1:0]   hash;
        logic [AVAIL_W-1:0]  av;
    } ring_result_t;

    logic [HASH_W-1:0]  ring_hash [REPLICA_SLOTS];
    logic [NODE_W-1:0]  ring_node [REPLICA_SLOTS];
    int                 ring_len;
    logic               present [NODE_SLOTS];
    logic [AVAIL_W-1:0] node_av [NODE_SLOTS];
    ring_result_t       expected_results [$];

    function automatic ring_result_t entry_at(int p);
        ring_result_t r;
        r.sts  = STS_OK;
        r.pos  = IDX_W'(p);
        r.node = ring_node[p];
        r.hash = ring_hash[p];
        r.av   = node_av[ring_node[p]];
        return r;
    endfunction

    function automatic ring_result_t ring_apply(action_t act, logic [NODE_W-1:0] id,
                                                logic [HASH_W-1:0] key,
                                                logic [AVAIL_W-1:0] av, int p);
        ring_result_t r;
        int ins;
        int w;
        int q;
        r = '0;
        r.sts = STS_OK;
        case (act)
            ACT_ADD_NODE:
            begin
                r.node = id;
                if (present[id])
                begin
                    r.sts = STS_EXISTS;
                    r.av  = node_av[id];
                end
                else
                begin
                    present[id] = 1'b1;
                    node_av[id] = av;
                    r.av = av;
                end
            end
            ACT_ADD_REP:
            begin
                if (!present[id])
                    r.sts = STS_UNKNOWN;
                else if (ring_len >= REPLICA_SLOTS)
                    r.sts = STS_FULL;
                else
                begin
                    ins = ring_len;
                    for (int i = 0; i < ring_len; i++)
                    begin
                        if (ring_hash[i] > key)
                        begin
                            ins = i;
                            break;
                        end
                    end
                    for (int i = ring_len; i > ins; i--)
                    begin
                        ring_hash[i] = ring_hash[i-1];
                        ring_node[i] = ring_node[i-1];
                    end
                    ring_hash[ins] = key;
                    ring_node[ins] = id;
                    ring_len++;
                    r = entry_at(ins);
                end
            end
            ACT_DELETE:
            begin
                if (!present[id])
                    r.sts = STS_UNKNOWN;
                else
                begin
                    present[id] = 1'b0;
                    w = 0;
                    for (int i = 0; i < ring_len; i++)
                    begin
                        if (ring_node[i] != id)
                        begin
                            ring_hash[w] = ring_hash[i];
                            ring_node[w] = ring_node[i];
                            w++;
                        end
                    end
                    ring_len = w;
                    r.node = id;
                end
            end
            ACT_FIND:
            begin
                if (ring_len == 0)
                    r.sts = STS_EMPTY;
                else
                begin
                    q = ring_len - 1;
                    for (int i = 0; i < ring_len; i++)
                    begin
                        if (ring_hash[i] <= key)
                            q = i;
                        else
                            break;
                    end
                    r = entry_at(q);
                end
            end
            ACT_NEXT:
            begin
                if (ring_len == 0)
                    r.sts = STS_EMPTY;
                else if (p >= ring_len)
                    r.sts = STS_BADPOS;
                else
                    r = entry_at((p + 1 == ring_len) ? 0 : p + 1);
            end
            ACT_RESERVE:
            begin
                if (ring_len == 0)
                    r.sts = STS_EMPTY;
                else if (p >= ring_len)
                    r.sts = STS_BADPOS;
                else
                begin
                    r.sts = STS_NONE;
                    q = p;
                    for (int i = 0; i < ring_len; i++)
                    begin
                        if (node_av[ring_node[q]] != 0)
                        begin
                            node_av[ring_node[q]]--;
                            r = entry_at(q);
                            break;
                        end
                        q = (q + 1 == ring_len) ? 0 : q + 1;
                    end
                end
            end
            default:
            begin
                // restore and query share the unknown-node check
                if (!present[id])
                    r.sts = STS_UNKNOWN;
                else
                begin
                    if (act == ACT_RESTORE && node_av[id] != '1)
                        node_av[id]++;
                    r.node = id;
                    r.av   = node_av[id];
                end
            end
        endcase
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        ring_result_t exp_r;
        ring_result_t got;
        if (!rst_n)
        begin
            ring_len = 0;
            for (int i = 0; i < NODE_SLOTS; i++)
            begin
                present[i] = 1'b0;
                node_av[i] = '0;
            end
            expected_results.delete();
            fail_count = 0;
            beats_in = 0;
            beats_out = 0;
        end
        else
        begin
            // check output first; a result never belongs to the beat taken this edge
            if (out_valid && !out_stall)
            begin
                beats_out++;
                got = {status_t'(status), position_out, node_out, hash_out, avail_out};
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result %h", $time, got);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got.sts !== exp_r.sts || got.pos !== exp_r.pos ||
                        got.node !== exp_r.node || got.hash !== exp_r.hash ||
                        got.av !== exp_r.av)
                    begin
                        fail_count++;
                        $display("%0t: mismatch exp sts=%0d pos=%0d node=%0d hash=%h av=%0d",
                                 $time, exp_r.sts, exp_r.pos, exp_r.node, exp_r.hash, exp_r.av);
                        $display("%0t:          act sts=%0d pos=%0d node=%0d hash=%h av=%0d",
                                 $time, got.sts, got.pos, got.node, got.hash, got.av);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                beats_in++;
                expected_results.push_back(ring_apply(action_t'(action), node_id, key_hash,
                                                      avail, int'(position)));
            end
        end
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import chrt_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [2:0]          action = '0;
    logic [NODE_W-1:0]   node_id = '0;
    logic [HASH_W-1:0]   key_hash = '0;
    logic [AVAIL_W-1:0]  avail = '0;
    logic [IDX_W-1:0]    position = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [2:0]          status;
    logic [IDX_W-1:0]    position_out;
    logic [NODE_W-1:0]   node_out;
    logic [HASH_W-1:0]   hash_out;
    logic [AVAIL_W-1:0]  avail_out;
    int                  fail_count;
    int                  pending;
    int                  beats_in;
    int                  beats_out;

    // idle percentages for sender and receiver, changed per phase
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    // rough guess at ring occupancy kept by the stimulus to aim positions
    int                  ring_guess = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    consistent_hash_ring_table dut (.*);

    chrt_checker u_checker (.*);

    // receiver stall pattern: redraw every cycle
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Drive one beat: optional idle cycles, then hold valid until taken.
    task automatic send_beat(action_t act, logic [NODE_W-1:0] id, logic [HASH_W-1:0] key,
                             logic [AVAIL_W-1:0] av, logic [IDX_W-1:0] p);
        logic taken;
        taken = 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        node_id  <= id;
        key_hash <= key;
        avail    <= av;
        position <= p;
        // stall only moves at rising edges; sample it mid-cycle for the next edge
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
    endtask

    function automatic logic [HASH_W-1:0] rand_hash();
        logic [HASH_W-1:0] h;
        case ($urandom_range(5))
            0: h = '0;
            1: h = '1;
            2: h = {60'h0, 4'($urandom)};
            default: h = {$urandom, $urandom};
        endcase
        return h;
    endfunction

    // Mostly well-formed traffic: nodes get added with replicas, then looked up,
    // reserved and restored; deletes and junk keep the ring churning.
    task automatic random_beat();
        action_t act;
        int p;
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            act = ACT_ADD_NODE;
        else if (pick < 35)
            act = ACT_ADD_REP;
        else if (pick < 39)
            act = ACT_DELETE;
        else if (pick < 52)
            act = ACT_FIND;
        else if (pick < 62)
            act = ACT_NEXT;
        else if (pick < 80)
            act = ACT_RESERVE;
        else if (pick < 90)
            act = ACT_RESTORE;
        else
            act = ACT_QUERY;
        // mostly legal positions, now and then past the end
        if (ring_guess > 0 && $urandom_range(9) != 0)
            p = $urandom_range(ring_guess - 1);
        else
            p = $urandom_range(255);
        send_beat(act, 4'($urandom), rand_hash(),
                  ($urandom_range(3) == 0) ? AVAIL_W'($urandom) : AVAIL_W'($urandom_range(3)),
                  IDX_W'(p));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        // no delete or reserve walk is still running once every result is back; the extra wait is idle margin
        repeat (REPLICA_SLOTS + 8) @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-ring and unknown-node errors
        send_beat(ACT_FIND, 4'd0, '1, '0, 8'd0);
        send_beat(ACT_NEXT, 4'd0, '0, '0, 8'd0);
        send_beat(ACT_RESERVE, 4'd0, '0, '0, 8'd0);
        send_beat(ACT_QUERY, 4'd5, '0, '0, 8'd0);
        send_beat(ACT_RESTORE, 4'd5, '0, '0, 8'd0);
        send_beat(ACT_DELETE, 4'd5, '0, '0, 8'd0);
        send_beat(ACT_ADD_REP, 4'd5, 64'h10, '0, 8'd0);
        // nodes at both ends, duplicate add, zero and max availability
        send_beat(ACT_ADD_NODE, 4'd0, '0, 16'd0, 8'd0);
        send_beat(ACT_ADD_NODE, 4'd15, '0, 16'hFFFF, 8'd0);
        send_beat(ACT_ADD_NODE, 4'd15, '0, 16'd3, 8'd0);
        send_beat(ACT_RESTORE, 4'd15, '0, '0, 8'd0);
        // replicas with extreme and equal hashes
        send_beat(ACT_ADD_REP, 4'd0, 64'h8000_0000_0000_0000, '0, 8'd0);
        send_beat(ACT_ADD_REP, 4'd15, '1, '0, 8'd0);
        send_beat(ACT_ADD_REP, 4'd15, '0, '0, 8'd0);
        send_beat(ACT_ADD_REP, 4'd0, '0, '0, 8'd0);
        // find at the lowest, a middle and the highest hash; next wraps; position past the end
        send_beat(ACT_FIND, 4'd0, 64'h0, '0, 8'd0);
        send_beat(ACT_FIND, 4'd0, 64'h8000_0000_0000_0000, '0, 8'd0);
        send_beat(ACT_FIND, 4'd0, '1, '0, 8'd0);
        send_beat(ACT_NEXT, 4'd0, '0, '0, 8'd3);
        send_beat(ACT_NEXT, 4'd0, '0, '0, 8'd255);
        // reserve takes node 15 at position 0, then nothing left after delete
        send_beat(ACT_RESERVE, 4'd0, '0, '0, 8'd0);
        send_beat(ACT_DELETE, 4'd15, '0, '0, 8'd0);
        send_beat(ACT_RESERVE, 4'd0, '0, '0, 8'd1);
        send_beat(ACT_QUERY, 4'd0, '0, '0, 8'd0);
        ring_guess = 2;
        drain();

        // fill the ring to overflow: 257 inserts on node 0
        send_idle_pct = 0;
        for (int i = 0; i < REPLICA_SLOTS + 1; i++)
        begin
            send_beat(ACT_ADD_REP, 4'd0, {$urandom, $urandom}, '0, '0);
        end
        send_beat(ACT_RESTORE, 4'd0, '0, '0, 8'd0);
        send_beat(ACT_RESERVE, 4'd0, '0, '0, 8'd255);
        send_beat(ACT_DELETE, 4'd0, '0, '0, 8'd0);
        ring_guess = 0;
        drain();

        // random phases with varied idling
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            for (int i = 0; i < 450; i++)
            begin
                random_beat();
                if (ring_guess < 40)
                    ring_guess++;
            end
            // hold off until every result is back
            drain();
        end

        recv_stall_pct = 0;
        drain();
        $display("Run took %0d beats in and %0d results out, ring filled past capacity,",
                 beats_in, beats_out);
        $display("every action and error status tried under four idle/stall mixes.");
        if (fail_count == 0 && pending == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    initial
    begin
        #100ms;
        $display("FAILURE");
        $finish;
    end

endmodule
